[sv/arm_inverse_kinematics_macros.svh]
// assertion macros for the arm inverse kinematics module
`ifndef ARM_INVERSE_KINEMATICS_MACROS_SVH
`define ARM_INVERSE_KINEMATICS_MACROS_SVH

// same-cycle implication, checked outside reset
`define AIK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define AIK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/aik_pkg.sv]
package aik_pkg;

    // pipeline section lengths
    localparam int SQ_A_N     = 23;
    localparam int SQ_C_N     = 31;
    localparam int DIV_N      = 30;
    localparam int CORDIC_N   = 20;
    localparam int SRCH_N     = 5;
    localparam int CORDIC_LAT = 1 + SRCH_N + 1 + CORDIC_N;

    // datapath widths
    localparam int ANG_W = 27;
    localparam int CV_W  = 34;
    localparam int SQ_W  = 62;
    localparam int DIV_W = 46;
    localparam int DEN_W = 44;

    // angles in 2^-16 degree
    localparam logic signed [ANG_W-1:0] HALF_TURN   = 27'sd11796480;
    localparam logic signed [ANG_W-1:0] RIGHT_ANGLE = 27'sd5898240;
    localparam logic signed [CV_W-1:0]  NORM_LIMIT  = 34'sd536870912;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } t_sq;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [DIV_N-1:0] q;
    } t_div;

    // arctan(2^-i) in 2^-16 degree
    function automatic logic signed [ANG_W-1:0] arc_tab(input logic [4:0] i);
        logic signed [ANG_W-1:0] a;
        case (i)
            5'd0:    a = 27'sd2949120;
            5'd1:    a = 27'sd1740967;
            5'd2:    a = 27'sd919879;
            5'd3:    a = 27'sd466945;
            5'd4:    a = 27'sd234379;
            5'd5:    a = 27'sd117304;
            5'd6:    a = 27'sd58666;
            5'd7:    a = 27'sd29335;
            5'd8:    a = 27'sd14668;
            5'd9:    a = 27'sd7334;
            5'd10:   a = 27'sd3667;
            5'd11:   a = 27'sd1833;
            5'd12:   a = 27'sd917;
            5'd13:   a = 27'sd458;
            5'd14:   a = 27'sd229;
            5'd15:   a = 27'sd115;
            5'd16:   a = 27'sd57;
            5'd17:   a = 27'sd29;
            5'd18:   a = 27'sd14;
            5'd19:   a = 27'sd7;
            default: a = '0;
        endcase
        return a;
    endfunction

    // one restoring square root step with bit weight 4^k
    function automatic t_sq sq_step(input t_sq s, input logic [4:0] k);
        logic [SQ_W-1:0] b;
        logic [SQ_W-1:0] rb;
        t_sq o;
        b  = SQ_W'(1) << {k, 1'b0};
        rb = s.r + b;
        if (s.v >= rb) begin
            o.v = s.v - rb;
            o.r = (s.r >> 1) + b;
        end else begin
            o.v = s.v;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // one restoring division step, one quotient bit
    function automatic t_div div_step(input t_div s);
        logic [DIV_W-1:0] sh;
        t_div o;
        sh  = {s.rem[DIV_W-2:0], 1'b0};
        o   = s;
        o.q = {s.q[DIV_N-2:0], 1'b0};
        if (sh >= DIV_W'(s.den)) begin
            o.rem  = sh - DIV_W'(s.den);
            o.q[0] = 1'b1;
        end else begin
            o.rem = sh;
        end
        return o;
    endfunction

endpackage

[sv/arm_inverse_kinematics.sv]
// Three-joint arm inverse kinematics. Each item is a target x, y, z in 1/64 mm and gives
// one result: base, lower and upper motor angles in 1/256 degree and a reachable flag
// (angles read 0 when unreachable). The block takes one item per clock while its results
// are taken. The pipeline holds two 23-stage square roots for the reach and the wrist
// distance, a 30-stage divider and a 31-stage square root for each acos argument, and
// 27-stage CORDIC units for the angles. A one-item skid buffer in front takes one more
// item while a finished result waits, so the input ready never follows the output ready
// in the same cycle, and the whole pipeline holds while a result is not taken.
`include "arm_inverse_kinematics_macros.svh"

module arm_inverse_kinematics (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_target_x,
    input  logic signed [15:0] i_target_y,
    input  logic signed [15:0] i_target_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [17:0] o_base_angle,
    output logic signed [17:0] o_lower_angle,
    output logic signed [17:0] o_upper_angle,
    output logic               o_reachable
);
    import aik_pkg::*;

    // stage numbers
    localparam int T_IN   = 1;
    localparam int T_S1   = T_IN + 2;
    localparam int T_R    = T_S1 + SQ_A_N;
    localparam int T_RZ   = T_R + 1;
    localparam int T_D2   = T_RZ + 2;
    localparam int T_D    = T_D2 + SQ_A_N;
    localparam int T_DIV  = T_D + 2;
    localparam int T_Q    = T_DIV + DIV_N;
    localparam int T_CC   = T_Q + 2;
    localparam int T_S    = T_CC + 1 + SQ_C_N;
    localparam int T_ANG  = T_S + CORDIC_LAT;
    localparam int T_OUT  = T_ANG + 1;

    // delay line lengths
    localparam int D_ZS   = T_R - T_IN;
    localparam int D_D2   = T_D - T_D2;
    localparam int D_FLG  = T_Q - T_DIV;
    localparam int D_C    = T_S - T_CC;
    localparam int D_BASE = T_ANG - (T_IN + CORDIC_LAT);
    localparam int D_PHI  = T_ANG - (T_RZ + CORDIC_LAT);
    localparam int D_OK   = T_ANG - T_DIV;
    localparam int D_Y0   = T_ANG - T_IN;

    localparam logic signed [46:0] UL_DIFF = 47'sd206304509952;
    localparam logic [SQ_W-1:0]    Q60_ONE = SQ_W'(1) << 60;

    // round half up to 1/256 degree, keep 18 bits
    function automatic logic [17:0] to_out(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] s;
        s = a + ANG_W'(128);
        return s[25:8];
    endfunction

    // handshake and skid buffer
    logic               r_skid_full;
    logic signed [15:0] r_skid_x, r_skid_y, r_skid_z;
    logic [T_OUT:1]     r_vld;
    logic               w_adv, w_acc, w_src_vld;
    logic signed [15:0] w_src_x, w_src_y, w_src_z;

    assign w_adv       = !r_vld[T_OUT] || i_out_ready;
    assign o_in_ready  = !r_skid_full;
    assign w_acc       = i_in_valid && !r_skid_full;
    assign w_src_vld   = r_skid_full || w_acc;
    assign w_src_x     = r_skid_full ? r_skid_x : i_target_x;
    assign w_src_y     = r_skid_full ? r_skid_y : i_target_y;
    assign w_src_z     = r_skid_full ? r_skid_z : i_target_z;
    assign o_out_valid = r_vld[T_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
            r_vld       <= '0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[T_OUT-1:1], w_src_vld};
            r_skid_full <= 1'b0;
        end else if (w_acc) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_adv && w_acc) begin
            r_skid_x <= i_target_x;
            r_skid_y <= i_target_y;
            r_skid_z <= i_target_z;
        end
    end

    // scale to 1/6400 mm and clamp x
    logic signed [23:0] w_xm;
    logic signed [23:0] r_xs, r_ys, r_zs;
    logic               r_y0;
    assign w_xm = 24'(w_src_x) * 24'sd100;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xs <= (w_xm < 24'sd640) ? 24'sd640 : w_xm;
            r_ys <= 24'(w_src_y) * 24'sd100;
            r_zs <= 24'(w_src_z) * 24'sd100;
            r_y0 <= (w_src_y == 16'sd0);
        end
    end

    // squared horizontal reach
    logic signed [47:0] w_xx, w_yy;
    logic [43:0]        r_xx, r_yy;
    logic [44:0]        r_s1;
    assign w_xx = 48'(r_xs) * 48'(r_xs);
    assign w_yy = 48'(r_ys) * 48'(r_ys);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xx <= w_xx[43:0];
            r_yy <= w_yy[43:0];
            r_s1 <= 45'(r_xx) + 45'(r_yy);
        end
    end

    // base angle unit
    logic signed [31:0]      w_bx, w_by;
    logic signed [ANG_W-1:0] w_base;
    assign w_bx = -(32'(r_ys));
    assign w_by = 32'(r_xs);

    aik_cordic u_base (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_x     (w_bx),
        .i_y     (w_by),
        .o_angle (w_base)
    );

    // reach square root
    t_sq r_sq1 [1:SQ_A_N];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq1[1] <= sq_step('{v: SQ_W'(r_s1), r: '0}, 5'(SQ_A_N - 1));
            for (int j = 2; j <= SQ_A_N; j++) begin
                r_sq1[j] <= sq_step(r_sq1[j-1], 5'(SQ_A_N - j));
            end
        end
    end

    // z travels alongside the root
    logic signed [23:0] r_zs_dl [1:D_ZS];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_zs_dl[1] <= r_zs;
            for (int k = 2; k <= D_ZS; k++) r_zs_dl[k] <= r_zs_dl[k-1];
        end
    end

    // shoulder-relative vector
    logic signed [23:0] r_rr, r_zz;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rr <= $signed({1'b0, r_sq1[SQ_A_N].r[22:0]}) - 24'sd446400;
            r_zz <= r_zs_dl[D_ZS] - 24'sd205120;
        end
    end

    // elevation unit
    logic signed [31:0]      w_fx, w_fy;
    logic signed [ANG_W-1:0] w_phi;
    assign w_fx = 32'(r_rr);
    assign w_fy = 32'(r_zz);

    aik_cordic u_phi (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_x     (w_fx),
        .i_y     (w_fy),
        .o_angle (w_phi)
    );

    // squared wrist distance
    logic signed [47:0] w_rr2, w_zz2;
    logic [44:0]        r_rr2, r_zz2;
    logic [45:0]        r_d2;
    assign w_rr2 = 48'(r_rr) * 48'(r_rr);
    assign w_zz2 = 48'(r_zz) * 48'(r_zz);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rr2 <= w_rr2[44:0];
            r_zz2 <= w_zz2[44:0];
            r_d2  <= 46'(r_rr2) + 46'(r_zz2);
        end
    end

    // distance square root, squared distance alongside
    t_sq         r_sq2   [1:SQ_A_N];
    logic [45:0] r_d2_dl [1:D_D2];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq2[1]   <= sq_step('{v: SQ_W'(r_d2), r: '0}, 5'(SQ_A_N - 1));
            r_d2_dl[1] <= r_d2;
            for (int j = 2; j <= SQ_A_N; j++) begin
                r_sq2[j] <= sq_step(r_sq2[j-1], 5'(SQ_A_N - j));
            end
            for (int k = 2; k <= D_D2; k++) r_d2_dl[k] <= r_d2_dl[k-1];
        end
    end

    // law of cosines numerators and denominators
    logic [22:0]       w_d;
    logic [DEN_W-1:0]  w_den_u, w_den_l;
    logic signed [46:0] r_num_u, r_num_l;
    logic [DEN_W-1:0]  r_den_u, r_den_l;
    logic              r_dnz;
    assign w_d     = r_sq2[SQ_A_N].r[22:0];
    assign w_den_u = DEN_W'(w_d) * 44'd2032768;
    assign w_den_l = DEN_W'(w_d) * 44'd1818496;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_num_u <= $signed({1'b0, r_d2_dl[D_D2]}) + UL_DIFF;
            r_num_l <= $signed({1'b0, r_d2_dl[D_D2]}) - UL_DIFF;
            r_den_u <= w_den_u;
            r_den_l <= w_den_l;
            r_dnz   <= (w_d != '0);
        end
    end

    // magnitude, range check and divider load
    logic [DIV_W-1:0] w_mag_u, w_mag_l;
    logic             w_bad_u, w_bad_l;
    t_div             r_div_u [0:DIV_N];
    t_div             r_div_l [0:DIV_N];
    logic [3:0]       r_flg;
    logic             r_ok;
    assign w_mag_u = r_num_u[46] ? DIV_W'(-r_num_u) : DIV_W'(r_num_u);
    assign w_mag_l = r_num_l[46] ? DIV_W'(-r_num_l) : DIV_W'(r_num_l);
    assign w_bad_u = w_mag_u > DIV_W'(r_den_u);
    assign w_bad_l = w_mag_l > DIV_W'(r_den_l);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_div_u[0] <= '{rem: w_mag_u, den: r_den_u, q: '0};
            r_div_l[0] <= '{rem: w_mag_l, den: r_den_l, q: '0};
            r_flg      <= {r_num_u[46], w_mag_u == DIV_W'(r_den_u),
                           r_num_l[46], w_mag_l == DIV_W'(r_den_l)};
            r_ok       <= r_dnz && !w_bad_u && !w_bad_l;
            for (int j = 1; j <= DIV_N; j++) begin
                r_div_u[j] <= div_step(r_div_u[j-1]);
                r_div_l[j] <= div_step(r_div_l[j-1]);
            end
        end
    end

    // sign and full-scale flags alongside the divider
    logic [3:0] r_flg_dl [1:D_FLG];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_flg_dl[1] <= r_flg;
            for (int k = 2; k <= D_FLG; k++) r_flg_dl[k] <= r_flg_dl[k-1];
        end
    end

    // cosine in Q30, its square and the sine squared
    logic [30:0]        r_cm_u, r_cm_l;
    logic               r_cn_u, r_cn_l;
    logic [61:0]        w_cc_u, w_cc_l;
    logic [61:0]        r_cc_u, r_cc_l;
    logic signed [31:0] r_c_u, r_c_l;
    logic [SQ_W-1:0]    r_v_u, r_v_l;
    assign w_cc_u = 62'(r_cm_u) * 62'(r_cm_u);
    assign w_cc_l = 62'(r_cm_l) * 62'(r_cm_l);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cm_u <= r_flg_dl[D_FLG][2] ? 31'h4000_0000 : {1'b0, r_div_u[DIV_N].q};
            r_cm_l <= r_flg_dl[D_FLG][0] ? 31'h4000_0000 : {1'b0, r_div_l[DIV_N].q};
            r_cn_u <= r_flg_dl[D_FLG][3];
            r_cn_l <= r_flg_dl[D_FLG][1];
            r_cc_u <= w_cc_u;
            r_cc_l <= w_cc_l;
            r_c_u  <= r_cn_u ? -$signed({1'b0, r_cm_u}) : $signed({1'b0, r_cm_u});
            r_c_l  <= r_cn_l ? -$signed({1'b0, r_cm_l}) : $signed({1'b0, r_cm_l});
            r_v_u  <= Q60_ONE - SQ_W'(r_cc_u);
            r_v_l  <= Q60_ONE - SQ_W'(r_cc_l);
        end
    end

    // sine square roots, cosines alongside
    t_sq                r_sq3u [1:SQ_C_N];
    t_sq                r_sq3l [1:SQ_C_N];
    logic signed [31:0] r_cu_dl [1:D_C];
    logic signed [31:0] r_cl_dl [1:D_C];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq3u[1]  <= sq_step('{v: r_v_u, r: '0}, 5'(SQ_C_N - 1));
            r_sq3l[1]  <= sq_step('{v: r_v_l, r: '0}, 5'(SQ_C_N - 1));
            r_cu_dl[1] <= r_c_u;
            r_cl_dl[1] <= r_c_l;
            for (int j = 2; j <= SQ_C_N; j++) begin
                r_sq3u[j] <= sq_step(r_sq3u[j-1], 5'(SQ_C_N - j));
                r_sq3l[j] <= sq_step(r_sq3l[j-1], 5'(SQ_C_N - j));
            end
            for (int k = 2; k <= D_C; k++) begin
                r_cu_dl[k] <= r_cu_dl[k-1];
                r_cl_dl[k] <= r_cl_dl[k-1];
            end
        end
    end

    // acos units
    logic signed [31:0]      w_su, w_sl;
    logic signed [ANG_W-1:0] w_aup, w_alow;
    assign w_su = 32'(r_sq3u[SQ_C_N].r[30:0]);
    assign w_sl = 32'(r_sq3l[SQ_C_N].r[30:0]);

    aik_cordic u_acos_up (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_x     (r_cu_dl[D_C]),
        .i_y     (w_su),
        .o_angle (w_aup)
    );

    aik_cordic u_acos_low (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_x     (r_cl_dl[D_C]),
        .i_y     (w_sl),
        .o_angle (w_alow)
    );

    // base, elevation and flags wait for the acos results
    logic signed [ANG_W-1:0] r_base_dl [1:D_BASE];
    logic signed [ANG_W-1:0] r_phi_dl  [1:D_PHI];
    logic                    r_ok_dl   [1:D_OK];
    logic                    r_y0_dl   [1:D_Y0];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_base_dl[1] <= w_base;
            r_phi_dl[1]  <= w_phi;
            r_ok_dl[1]   <= r_ok;
            r_y0_dl[1]   <= r_y0;
            for (int k = 2; k <= D_BASE; k++) r_base_dl[k] <= r_base_dl[k-1];
            for (int k = 2; k <= D_PHI; k++)  r_phi_dl[k]  <= r_phi_dl[k-1];
            for (int k = 2; k <= D_OK; k++)   r_ok_dl[k]   <= r_ok_dl[k-1];
            for (int k = 2; k <= D_Y0; k++)   r_y0_dl[k]   <= r_y0_dl[k-1];
        end
    end

    // output register
    logic signed [ANG_W-1:0] w_base_sel, w_low, w_up;
    assign w_base_sel = r_y0_dl[D_Y0] ? RIGHT_ANGLE : r_base_dl[D_BASE];
    assign w_low      = w_alow + r_phi_dl[D_PHI];
    assign w_up       = w_aup - r_phi_dl[D_PHI];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_reachable   <= r_ok_dl[D_OK];
            o_base_angle  <= r_ok_dl[D_OK] ? $signed(to_out(w_base_sel)) : 18'sd0;
            o_lower_angle <= r_ok_dl[D_OK] ? $signed(to_out(w_low)) : 18'sd0;
            o_upper_angle <= r_ok_dl[D_OK] ? $signed(to_out(w_up)) : 18'sd0;
        end
    end

    // checks
    logic w_unreach, w_ang_zero, w_base_in;
    assign w_unreach  = o_out_valid && !o_reachable;
    assign w_ang_zero = o_base_angle == 18'sd0 && o_lower_angle == 18'sd0
                        && o_upper_angle == 18'sd0;
    assign w_base_in  = o_base_angle <= 18'sd46336 && o_base_angle >= -18'sd46336;

    `AIK_ASSERT_IMP(a_unreach_zero, w_unreach, w_ang_zero, "unreachable item with an angle")
    `AIK_ASSERT_IMP(a_base_range, o_out_valid, w_base_in, "base angle beyond a half turn")
    `AIK_ASSERT_NXT(a_skid_drain, r_skid_full && w_adv, r_vld[1], "skid item lost on advance")

endmodule

[sv/aik_cordic.sv]
module aik_cordic (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [31:0]                i_x,
    input  logic signed [31:0]                i_y,
    output logic signed [aik_pkg::ANG_W-1:0]  o_angle
);
    import aik_pkg::*;

    logic signed [CV_W-1:0]  w_xe, w_ye;
    logic signed [CV_W-1:0]  n_px, n_py;
    logic signed [ANG_W-1:0] n_pacc;
    logic                    n_pout;

    // index 0 is the prerotation stage, then the shift search stages
    logic signed [CV_W-1:0]  r_sx   [0:SRCH_N];
    logic signed [CV_W-1:0]  r_sy   [0:SRCH_N];
    logic signed [ANG_W-1:0] r_sacc [0:SRCH_N];
    logic                    r_sout [0:SRCH_N];

    // index 0 is the final doubling, then one stage per rotation
    logic signed [CV_W-1:0]  r_cx   [0:CORDIC_N];
    logic signed [CV_W-1:0]  r_cy   [0:CORDIC_N];
    logic signed [ANG_W-1:0] r_cacc [0:CORDIC_N];

    // half-turn prerotation for a negative x part
    always_comb begin
        w_xe   = CV_W'(i_x);
        w_ye   = CV_W'(i_y);
        n_px   = w_xe;
        n_py   = w_ye;
        n_pacc = '0;
        if (w_xe < 0) begin
            n_px   = -w_xe;
            n_py   = -w_ye;
            n_pacc = (w_ye >= 0) ? HALF_TURN : -HALF_TURN;
        end
        n_pout = (n_px >= NORM_LIMIT) || (n_py >= NORM_LIMIT) || (n_py <= -NORM_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx[0]   <= n_px;
            r_sy[0]   <= n_py;
            r_sacc[0] <= n_pacc;
            r_sout[0] <= n_pout;
        end
    end

    // binary search for the largest doubling count that stays inside the limit
    for (genvar j = 0; j < SRCH_N; j++) begin : g_srch
        localparam int SH = 16 >> j;
        localparam logic signed [CV_W-1:0] LIM = NORM_LIMIT >>> SH;
        logic w_in;
        assign w_in = !r_sout[j] && (r_sx[j] < LIM) && (r_sy[j] < LIM) && (r_sy[j] > -LIM);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sx[j+1]   <= w_in ? (r_sx[j] <<< SH) : r_sx[j];
                r_sy[j+1]   <= w_in ? (r_sy[j] <<< SH) : r_sy[j];
                r_sacc[j+1] <= r_sacc[j];
                r_sout[j+1] <= r_sout[j];
            end
        end
    end

    // one more doubling takes the vector past the limit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0]   <= r_sout[SRCH_N] ? r_sx[SRCH_N] : (r_sx[SRCH_N] <<< 1);
            r_cy[0]   <= r_sout[SRCH_N] ? r_sy[SRCH_N] : (r_sy[SRCH_N] <<< 1);
            r_cacc[0] <= r_sacc[SRCH_N];
        end
    end

    // vectoring rotations
    for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
        localparam logic signed [ANG_W-1:0] ARC = arc_tab(5'(i));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_cy[i] >= 0) begin
                    r_cx[i+1]   <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1]   <= r_cy[i] - (r_cx[i] >>> i);
                    r_cacc[i+1] <= r_cacc[i] + ARC;
                end else begin
                    r_cx[i+1]   <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1]   <= r_cy[i] + (r_cx[i] >>> i);
                    r_cacc[i+1] <= r_cacc[i] - ARC;
                end
            end
        end
    end

    assign o_angle = r_cacc[CORDIC_N];

endmodule
